// ----- rtl/angle_sensor_frame_checker_unit_defines.svh -----
// shared assertion macros for the frame checker
`ifndef ANGLE_SENSOR_FRAME_CHECKER_UNIT_DEFINES_SVH
`define ANGLE_SENSOR_FRAME_CHECKER_UNIT_DEFINES_SVH

// same-cycle implication
`define ASFC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frame checker assertion failed");

// next-cycle implication
`define ASFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frame checker assertion failed");

`endif

// ----- rtl/asfc_pkg.sv -----
`default_nettype none

package asfc_pkg;

    localparam int unsigned CfgIdxW = 4;
    localparam logic [7:0]  CrcPoly = 8'h07;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_CRC_SEED        = 4'd0,
        CFG_CRC_CHECK_EN    = 4'd1,
        CFG_FIXED_CHECK_EN  = 4'd2,
        CFG_STATUS_FAIL_EN  = 4'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_TRANSFER = 3'd1,
        ERR_CRC      = 3'd2,
        ERR_FIXED    = 3'd3,
        ERR_STATUS   = 3'd4
    } t_err;

    typedef struct packed {
        logic [7:0] crc_seed;
        logic       crc_check_en;
        logic       fixed_check_en;
        logic       status_fail_en;
    } t_cfg;

    typedef struct packed {
        logic       transfer_ok;
        logic [7:0] angle_high_byte;
        logic [7:0] angle_low_byte;
        logic [7:0] status_byte;
        logic [7:0] received_crc;
    } t_frame;

    typedef struct packed {
        logic [14:0] angle;
        logic [2:0]  status_bits;
        logic [7:0]  crc_from_sensor;
        logic [7:0]  crc_computed;
        logic        crc_bad;
        logic        fixed_bad;
        logic        status_warn;
        logic        sample_valid;
    } t_check;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] crc;
        logic [7:0] d;
        logic       fb;
        crc = crc_in;
        d   = data;
        for (int k = 0; k < 8; k++) begin
            fb  = crc[7] ^ d[7];
            crc = {crc[6:0], 1'b0};
            if (fb) begin
                crc = crc ^ CrcPoly;
            end
            d = {d[6:0], 1'b0};
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/asfc_frame_check.sv -----
`default_nettype none

module asfc_frame_check (
    input  var asfc_pkg::t_frame i_frame,
    input  var asfc_pkg::t_cfg   i_cfg,
    output asfc_pkg::t_check     o_check
);

    logic [7:0] crc_a;
    logic [7:0] crc_b;
    logic [7:0] crc_c;
    logic       fixed_bad;
    logic       crc_bad;
    logic       status_nz;
    logic       valid;

    assign crc_a = asfc_pkg::crc8_byte(i_cfg.crc_seed, i_frame.angle_high_byte);
    assign crc_b = asfc_pkg::crc8_byte(crc_a, i_frame.angle_low_byte);
    assign crc_c = asfc_pkg::crc8_byte(crc_b, i_frame.status_byte);

    assign fixed_bad = i_frame.angle_low_byte[0] | (|i_frame.status_byte[7:3]);
    assign crc_bad   = (crc_c != i_frame.received_crc);
    assign status_nz = |i_frame.status_byte[2:0];

    assign valid = !(i_cfg.fixed_check_en && fixed_bad)
                && !(i_cfg.crc_check_en && crc_bad)
                && !(i_cfg.status_fail_en && status_nz);

    always_comb begin
        o_check = '0;
        if (i_frame.transfer_ok) begin
            o_check.angle           = {i_frame.angle_high_byte, i_frame.angle_low_byte[7:1]};
            o_check.status_bits     = i_frame.status_byte[2:0];
            o_check.crc_from_sensor = i_frame.received_crc;
            o_check.crc_computed    = crc_c;
            o_check.crc_bad         = crc_bad;
            o_check.fixed_bad       = fixed_bad;
            o_check.status_warn     = status_nz;
            o_check.sample_valid    = valid;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/angle_sensor_frame_checker_unit.sv -----
// channel | direction | handshake                | beat
// --------+-----------+--------------------------+-----------------------------------
// input   | in        | i_valid / o_stall        | transfer_ok and four frame bytes
// result  | out       | o_valid / i_stall        | sample fields and counters
// config  | in        | i_cfg_valid / o_cfg_ready| register index and write data
//
// one beat per cycle sustained while i_stall is low; input register, then result register
// crc-8 over three bytes and the counter updates sit between the two registers
// i_rst_n is synchronous, active low; clears counters, sequence and error, config to defaults
// a stalled result holds; the input register still takes one beat, then o_stall rises

`default_nettype none

module angle_sensor_frame_checker_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_transfer_ok,
    input  wire logic [7:0]                    i_angle_high_byte,
    input  wire logic [7:0]                    i_angle_low_byte,
    input  wire logic [7:0]                    i_status_byte,
    input  wire logic [7:0]                    i_received_crc,

    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [14:0]                        o_angle,
    output logic [2:0]                         o_status_bits,
    output logic [7:0]                         o_crc_from_sensor,
    output logic [7:0]                         o_crc_computed,
    output logic                               o_sample_valid,
    output logic [31:0]                        o_sample_sequence,
    output logic [2:0]                         o_error_code,
    output logic [31:0]                        o_good_sample_count,
    output logic [31:0]                        o_transfer_fail_count,
    output logic [31:0]                        o_crc_fail_count,
    output logic [31:0]                        o_fixed_bit_fail_count,
    output logic [31:0]                        o_status_warn_count,

    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [asfc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [7:0]                    i_cfg_data
);

    asfc_pkg::t_cfg   r_cfg;
    asfc_pkg::t_frame r_in;
    logic             r_in_valid;
    logic             r_out_valid;
    asfc_pkg::t_check chk;

    logic             out_adv;
    logic             move;
    logic             in_take;

    logic [14:0]      r_out_angle;
    logic [2:0]       r_out_status;
    logic [7:0]       r_out_rcrc;
    logic [7:0]       r_out_ccrc;
    logic             r_out_sample_valid;
    logic [31:0]      r_out_seq;

    logic [31:0]      r_last_seq;
    logic [31:0]      r_good_cnt;
    logic [31:0]      r_xfer_cnt;
    logic [31:0]      r_crc_cnt;
    logic [31:0]      r_fixed_cnt;
    logic [31:0]      r_warn_cnt;
    asfc_pkg::t_err   r_err;

    logic [31:0]      n_last_seq;
    logic [31:0]      n_good_cnt;
    logic [31:0]      n_xfer_cnt;
    logic [31:0]      n_crc_cnt;
    logic [31:0]      n_fixed_cnt;
    logic [31:0]      n_warn_cnt;
    asfc_pkg::t_err   n_err;
    logic [31:0]      n_seq;

    assign out_adv = !r_out_valid || !i_stall;
    assign move    = r_in_valid && out_adv;
    assign o_stall = r_in_valid && !out_adv;
    assign in_take = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crc_seed       <= 8'd0;
            r_cfg.crc_check_en   <= 1'b1;
            r_cfg.fixed_check_en <= 1'b1;
            r_cfg.status_fail_en <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                asfc_pkg::CFG_CRC_SEED:       r_cfg.crc_seed       <= i_cfg_data;
                asfc_pkg::CFG_CRC_CHECK_EN:   r_cfg.crc_check_en   <= i_cfg_data[0];
                asfc_pkg::CFG_FIXED_CHECK_EN: r_cfg.fixed_check_en <= i_cfg_data[0];
                asfc_pkg::CFG_STATUS_FAIL_EN: r_cfg.status_fail_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.transfer_ok     <= i_transfer_ok;
            r_in.angle_high_byte <= i_angle_high_byte;
            r_in.angle_low_byte  <= i_angle_low_byte;
            r_in.status_byte     <= i_status_byte;
            r_in.received_crc    <= i_received_crc;
        end
    end

    asfc_frame_check u_check (
        .i_frame (r_in),
        .i_cfg   (r_cfg),
        .o_check (chk)
    );

    // counter and error update for one frame
    always_comb begin
        n_last_seq  = r_last_seq;
        n_good_cnt  = r_good_cnt;
        n_xfer_cnt  = r_xfer_cnt;
        n_crc_cnt   = r_crc_cnt;
        n_fixed_cnt = r_fixed_cnt;
        n_warn_cnt  = r_warn_cnt;
        n_err       = r_err;
        n_seq       = 32'd0;
        if (!r_in.transfer_ok) begin
            n_xfer_cnt = r_xfer_cnt + 32'd1;
            n_err      = asfc_pkg::ERR_TRANSFER;
        end else begin
            n_seq      = r_last_seq + 32'd1;
            n_last_seq = n_seq;
            if (chk.status_warn) begin
                n_warn_cnt = r_warn_cnt + 32'd1;
                if (r_cfg.status_fail_en) begin
                    n_err = asfc_pkg::ERR_STATUS;
                end
            end
            if (!chk.sample_valid) begin
                if (chk.crc_bad) begin
                    n_crc_cnt = r_crc_cnt + 32'd1;
                    n_err     = asfc_pkg::ERR_CRC;
                end
                if (r_cfg.fixed_check_en && chk.fixed_bad) begin
                    n_fixed_cnt = r_fixed_cnt + 32'd1;
                    n_err       = asfc_pkg::ERR_FIXED;
                end
            end else begin
                n_good_cnt = r_good_cnt + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_last_seq  <= 32'd0;
            r_good_cnt  <= 32'd0;
            r_xfer_cnt  <= 32'd0;
            r_crc_cnt   <= 32'd0;
            r_fixed_cnt <= 32'd0;
            r_warn_cnt  <= 32'd0;
            r_err       <= asfc_pkg::ERR_NONE;
        end else if (move) begin
            r_out_valid <= 1'b1;
            r_last_seq  <= n_last_seq;
            r_good_cnt  <= n_good_cnt;
            r_xfer_cnt  <= n_xfer_cnt;
            r_crc_cnt   <= n_crc_cnt;
            r_fixed_cnt <= n_fixed_cnt;
            r_warn_cnt  <= n_warn_cnt;
            r_err       <= n_err;
        end else if (out_adv) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_angle        <= chk.angle;
            r_out_status       <= chk.status_bits;
            r_out_rcrc         <= chk.crc_from_sensor;
            r_out_ccrc         <= chk.crc_computed;
            r_out_sample_valid <= chk.sample_valid;
            r_out_seq          <= n_seq;
        end
    end

    // counters only move when a new result loads, so they match the held beat
    assign o_valid                = r_out_valid;
    assign o_angle                = r_out_angle;
    assign o_status_bits          = r_out_status;
    assign o_crc_from_sensor      = r_out_rcrc;
    assign o_crc_computed         = r_out_ccrc;
    assign o_sample_valid         = r_out_sample_valid;
    assign o_sample_sequence      = r_out_seq;
    assign o_error_code           = r_err;
    assign o_good_sample_count    = r_good_cnt;
    assign o_transfer_fail_count  = r_xfer_cnt;
    assign o_crc_fail_count       = r_crc_cnt;
    assign o_fixed_bit_fail_count = r_fixed_cnt;
    assign o_status_warn_count    = r_warn_cnt;

endmodule

`default_nettype wire

// ----- rtl/asfc_checker.sv -----
`default_nettype none

`include "angle_sensor_frame_checker_unit_defines.svh"

module asfc_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_stall,
    input wire logic                          o_valid,
    input wire logic                          i_stall,
    input wire logic [14:0]                   o_angle,
    input wire logic                          o_sample_valid,
    input wire logic [31:0]                   o_sample_sequence,
    input wire logic [2:0]                    o_error_code,
    input wire logic [31:0]                   o_good_sample_count,
    input wire logic [31:0]                   o_transfer_fail_count
);

    logic [31:0] good_plus_one;

    assign good_plus_one = o_good_sample_count + 32'd1;

    // stalled result beat holds
    `ASFC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_sample_sequence) && $stable(o_angle)
        && $stable(o_sample_valid) && $stable(o_error_code))

    // input side only backs up behind a stalled full result
    `ASFC_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)

    // a clean error code means no transfer has ever failed
    `ASFC_ASSERT_NOW(a_err_clean, i_clk, i_rst_n,
        o_error_code == asfc_pkg::ERR_NONE, o_transfer_fail_count == 32'd0)

    // good count only steps by one, and only with a valid sample shown
    `ASFC_ASSERT_NEXT(a_good_step, i_clk, i_rst_n, i_rst_n,
        $stable(o_good_sample_count)
        || (o_good_sample_count == $past(good_plus_one) && o_valid && o_sample_valid))

endmodule

bind angle_sensor_frame_checker_unit asfc_checker u_asfc_checker (.*);

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

typedef struct packed {
    logic [14:0] angle;
    logic [2:0]  status;
    logic [7:0]  crc_rx;
    logic [7:0]  crc_local;
    logic        valid;
    logic [31:0] seq;
    logic [2:0]  err;
    logic [31:0] good_cnt;
    logic [31:0] xfer_fail_cnt;
    logic [31:0] crc_fail_cnt;
    logic [31:0] fixed_fail_cnt;
    logic [31:0] warn_cnt;
} t_sample;

class sample_tracker;
    logic [7:0]      seed;
    logic            crc_en;
    logic            fix_en;
    logic            st_en;
    logic [31:0]     last_seq;
    logic [31:0]     good_cnt;
    logic [31:0]     xfer_fail_cnt;
    logic [31:0]     crc_fail_cnt;
    logic [31:0]     fixed_fail_cnt;
    logic [31:0]     warn_cnt;
    asfc_pkg::t_err  held_err;
    t_sample         expected_q[$];
    int unsigned     mismatches;

    function new();
        seed           = 8'h00;
        crc_en         = 1'b1;
        fix_en         = 1'b1;
        st_en          = 1'b0;
        last_seq       = '0;
        good_cnt       = '0;
        xfer_fail_cnt  = '0;
        crc_fail_cnt   = '0;
        fixed_fail_cnt = '0;
        warn_cnt       = '0;
        held_err       = asfc_pkg::ERR_NONE;
        mismatches     = 0;
    endfunction

    function void write_reg(logic [asfc_pkg::CfgIdxW-1:0] idx, logic [7:0] data);
        case (idx)
            asfc_pkg::CFG_CRC_SEED: begin
                seed = data;
            end
            asfc_pkg::CFG_CRC_CHECK_EN: begin
                crc_en = data[0];
            end
            asfc_pkg::CFG_FIXED_CHECK_EN: begin
                fix_en = data[0];
            end
            asfc_pkg::CFG_STATUS_FAIL_EN: begin
                st_en = data[0];
            end
            default: begin
            end
        endcase
    endfunction

    // msb-first crc-8 over the three data bytes as one 24-bit message
    function logic [7:0] crc_of(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
        logic [23:0] msg;
        logic [7:0]  r;
        msg = {b0, b1, b2};
        r   = seed;
        for (int k = 23; k >= 0; k--) begin
            r = {r[6:0], 1'b0} ^ ((r[7] ^ msg[k]) ? asfc_pkg::CrcPoly : 8'h00);
        end
        return r;
    endfunction

    function void note_frame(asfc_pkg::t_frame f);
        t_sample s;
        logic    fixed_bad;
        logic    crc_bad;
        s = '0;
        if (!f.transfer_ok) begin
            xfer_fail_cnt += 1;
            held_err = asfc_pkg::ERR_TRANSFER;
        end else begin
            fixed_bad   = f.angle_low_byte[0] || (f.status_byte[7:3] != 5'd0);
            s.seq       = last_seq + 32'd1;
            s.angle     = {f.angle_high_byte, f.angle_low_byte[7:1]};
            s.status    = f.status_byte[2:0];
            s.crc_rx    = f.received_crc;
            s.crc_local = crc_of(f.angle_high_byte, f.angle_low_byte, f.status_byte);
            crc_bad     = (s.crc_local != s.crc_rx);
            s.valid     = !((fix_en && fixed_bad) || (crc_en && crc_bad) ||
                            (st_en && s.status != 3'd0));
            if (s.status != 3'd0) begin
                warn_cnt += 1;
                if (st_en) begin
                    held_err = asfc_pkg::ERR_STATUS;
                end
            end
            if (!s.valid) begin
                if (crc_bad) begin
                    crc_fail_cnt += 1;
                    held_err = asfc_pkg::ERR_CRC;
                end
                if (fix_en && fixed_bad) begin
                    fixed_fail_cnt += 1;
                    held_err = asfc_pkg::ERR_FIXED;
                end
            end
            last_seq = s.seq;
            if (s.valid) begin
                good_cnt += 1;
            end
        end
        s.err            = held_err;
        s.good_cnt       = good_cnt;
        s.xfer_fail_cnt  = xfer_fail_cnt;
        s.crc_fail_cnt   = crc_fail_cnt;
        s.fixed_fail_cnt = fixed_fail_cnt;
        s.warn_cnt       = warn_cnt;
        expected_q.push_back(s);
    endfunction

    task report(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report($sformatf("%s got %0h expected %0h", what, got, want));
        end
    endtask

    task check_sample(t_sample got);
        t_sample e;
        if (expected_q.size() == 0) begin
            report("result beat with nothing expected");
        end else begin
            e = expected_q.pop_front();
            check_field("angle", 32'(got.angle), 32'(e.angle));
            check_field("status_bits", 32'(got.status), 32'(e.status));
            check_field("crc_from_sensor", 32'(got.crc_rx), 32'(e.crc_rx));
            check_field("crc_computed", 32'(got.crc_local), 32'(e.crc_local));
            check_field("sample_valid", 32'(got.valid), 32'(e.valid));
            check_field("sample_sequence", got.seq, e.seq);
            check_field("error_code", 32'(got.err), 32'(e.err));
            check_field("good_sample_count", got.good_cnt, e.good_cnt);
            check_field("transfer_fail_count", got.xfer_fail_cnt, e.xfer_fail_cnt);
            check_field("crc_fail_count", got.crc_fail_cnt, e.crc_fail_cnt);
            check_field("fixed_bit_fail_count", got.fixed_fail_cnt, e.fixed_fail_cnt);
            check_field("status_warn_count", got.warn_cnt, e.warn_cnt);
        end
    endtask
endclass

module tb;
    localparam int unsigned IdxW        = asfc_pkg::CfgIdxW;
    localparam int unsigned CfgRegCount = 4;
    localparam int unsigned QuietLimit  = 3000;
    localparam int unsigned PhaseItems  = 200;
    localparam int unsigned HoldCycles  = 300;

    logic                i_clk;
    logic                i_rst_n             = 1'b0;
    logic                i_valid             = 1'b0;
    logic                o_stall;
    logic                i_transfer_ok       = 1'b0;
    logic [7:0]          i_angle_high_byte   = 8'h00;
    logic [7:0]          i_angle_low_byte    = 8'h00;
    logic [7:0]          i_status_byte       = 8'h00;
    logic [7:0]          i_received_crc      = 8'h00;
    logic                o_valid;
    logic                i_stall             = 1'b0;
    logic [14:0]         o_angle;
    logic [2:0]          o_status_bits;
    logic [7:0]          o_crc_from_sensor;
    logic [7:0]          o_crc_computed;
    logic                o_sample_valid;
    logic [31:0]         o_sample_sequence;
    logic [2:0]          o_error_code;
    logic [31:0]         o_good_sample_count;
    logic [31:0]         o_transfer_fail_count;
    logic [31:0]         o_crc_fail_count;
    logic [31:0]         o_fixed_bit_fail_count;
    logic [31:0]         o_status_warn_count;
    logic                i_cfg_valid         = 1'b0;
    logic                o_cfg_ready;
    logic [IdxW-1:0]     i_cfg_index         = '0;
    logic [7:0]          i_cfg_data          = 8'h00;

    sample_tracker sb;
    logic          send_gaps = 1'b1;
    logic          recv_gaps = 1'b1;
    int unsigned   hold_req  = 0;

    angle_sensor_frame_checker_unit i_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_stall                (o_stall),
        .i_transfer_ok          (i_transfer_ok),
        .i_angle_high_byte      (i_angle_high_byte),
        .i_angle_low_byte       (i_angle_low_byte),
        .i_status_byte          (i_status_byte),
        .i_received_crc         (i_received_crc),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_angle                (o_angle),
        .o_status_bits          (o_status_bits),
        .o_crc_from_sensor      (o_crc_from_sensor),
        .o_crc_computed         (o_crc_computed),
        .o_sample_valid         (o_sample_valid),
        .o_sample_sequence      (o_sample_sequence),
        .o_error_code           (o_error_code),
        .o_good_sample_count    (o_good_sample_count),
        .o_transfer_fail_count  (o_transfer_fail_count),
        .o_crc_fail_count       (o_crc_fail_count),
        .o_fixed_bit_fail_count (o_fixed_bit_fail_count),
        .o_status_warn_count    (o_status_warn_count),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: check accepted beats, then pick next stall
    initial begin
        t_sample     got;
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.angle          = o_angle;
                got.status         = o_status_bits;
                got.crc_rx         = o_crc_from_sensor;
                got.crc_local      = o_crc_computed;
                got.valid          = o_sample_valid;
                got.seq            = o_sample_sequence;
                got.err            = o_error_code;
                got.good_cnt       = o_good_sample_count;
                got.xfer_fail_cnt  = o_transfer_fail_count;
                got.crc_fail_cnt   = o_crc_fail_count;
                got.fixed_fail_cnt = o_fixed_bit_fail_count;
                got.warn_cnt       = o_status_warn_count;
                sb.check_sample(got);
            end
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (recv_gaps) begin
                i_stall <= ($urandom_range(99) < 37);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QuietLimit) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb NOT OK");
        $finish;
    end

    task send_frame(asfc_pkg::t_frame f);
        if (send_gaps) begin
            while ($urandom_range(99) < 37) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid           <= 1'b1;
        i_transfer_ok     <= f.transfer_ok;
        i_angle_high_byte <= f.angle_high_byte;
        i_angle_low_byte  <= f.angle_low_byte;
        i_status_byte     <= f.status_byte;
        i_received_crc    <= f.received_crc;
        do @(posedge i_clk); while (o_stall);
        sb.note_frame(f);
    endtask

    task wait_idle();
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // all four registers, then a write to an unused index that must change nothing
    task apply_settings(logic [7:0] seed, logic crc_en, logic fix_en, logic st_en);
        logic [IdxW-1:0] idx [5];
        logic [7:0]      val [5];
        idx[0] = asfc_pkg::CFG_CRC_SEED;
        val[0] = seed;
        idx[1] = asfc_pkg::CFG_CRC_CHECK_EN;
        val[1] = (8'($urandom) & 8'hFE) | 8'(crc_en);
        idx[2] = asfc_pkg::CFG_FIXED_CHECK_EN;
        val[2] = (8'($urandom) & 8'hFE) | 8'(fix_en);
        idx[3] = asfc_pkg::CFG_STATUS_FAIL_EN;
        val[3] = (8'($urandom) & 8'hFE) | 8'(st_en);
        idx[4] = IdxW'($urandom_range((1 << IdxW) - 1, CfgRegCount));
        val[4] = 8'($urandom);
        for (int n = 0; n < 5; n++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[n];
            i_cfg_data  <= val[n];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.write_reg(idx[n], val[n]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function asfc_pkg::t_frame make_frame(logic ok, logic [7:0] b0, logic [7:0] b1,
                                          logic [7:0] b2, logic [7:0] crc_flip);
        asfc_pkg::t_frame f;
        f.transfer_ok     = ok;
        f.angle_high_byte = b0;
        f.angle_low_byte  = b1;
        f.status_byte     = b2;
        f.received_crc    = sb.crc_of(b0, b1, b2) ^ crc_flip;
        return f;
    endfunction

    // mostly well-formed reads with random content, some corrupted or failed
    function asfc_pkg::t_frame rand_frame();
        int unsigned pick;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  flip;
        pick = $urandom_range(99);
        b1   = 8'($urandom) & 8'hFE;
        b2   = ($urandom_range(1) != 0) ? 8'($urandom_range(7)) : 8'h00;
        flip = 8'h00;
        if (pick < 8) begin
            return make_frame(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
        if (pick < 16) begin
            return make_frame(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
        if ($urandom_range(99) < 12) begin
            flip = 8'($urandom_range(255, 1));
        end
        if ($urandom_range(99) < 10) begin
            b1 = b1 | 8'($urandom_range(1));
            b2 = b2 | (8'($urandom) & 8'hF8);
        end
        return make_frame(1'b1, 8'($urandom), b1, b2, flip);
    endfunction

    task run_directed();
        send_frame(make_frame(1'b1, 8'h00, 8'h00, 8'h00, 8'h00));
        send_frame(make_frame(1'b1, 8'hFF, 8'hFE, 8'h00, 8'h00));
        send_frame(make_frame(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h5A));
        send_frame(make_frame(1'b1, 8'h5A, 8'hA4, 8'h07, 8'h00));
        send_frame(make_frame(1'b1, 8'h12, 8'h34, 8'h00, 8'h01));
        send_frame(make_frame(1'b1, 8'h80, 8'h01, 8'h00, 8'h00));
        send_frame(make_frame(1'b1, 8'h01, 8'h00, 8'hF8, 8'h00));
        send_frame(make_frame(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'h80));
        send_frame(make_frame(1'b1, 8'h00, 8'h00, 8'h03, 8'h55));
        send_frame(make_frame(1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
        send_frame(make_frame(1'b1, 8'h7F, 8'hFE, 8'h00, 8'h00));
        i_valid <= 1'b0;
    endtask

    initial begin
        logic [7:0] seed;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings first, then the opposite corner
        run_directed();
        wait_idle();
        apply_settings(8'hFF, 1'b0, 1'b0, 1'b1);
        run_directed();
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            seed = (p == 0) ? 8'h00 : (p == 7) ? 8'hFF : 8'($urandom);
            apply_settings(seed, p[0], p[1], p[2]);
            send_gaps = !(p == 2 || p == 3);
            recv_gaps = send_gaps;
            if (p == 5) begin
                hold_req = HoldCycles;
            end
            for (int n = 0; n < PhaseItems; n++) begin
                send_frame(rand_frame());
            end
            i_valid <= 1'b0;
            wait_idle();
        end

        if (sb.mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
